>>> hw/rtl/chm_pkg.sv
// Shared types, constants and helpers for the coalesced hash map core.
package chm_pkg;

    // Table size; the home-slot reduction below takes the key magnitude modulo this value.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int SLOT_W   = IDX_W + 1;      // slot index plus null code
    localparam int CNT_W    = SLOT_W;

    localparam logic [SLOT_W-1:0] NULL_LINK = SLOT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        CMD_ADD     = 2'd0,
        CMD_SEARCH  = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_REPLACE = 2'd3
    } t_cmd;

    // Step the controller asks the datapath to perform this cycle.
    typedef enum logic [3:0] {
        OP_NONE      = 4'd0,
        OP_LOAD      = 4'd1,
        OP_WALK      = 4'd2,
        OP_FREE      = 4'd3,
        OP_RM_WALK   = 4'd4,
        OP_RM_ROUND  = 4'd5,
        OP_RM_SEEK   = 4'd6,
        OP_RM_UNLINK = 4'd7,
        OP_RM_SCAN   = 4'd8,
        OP_RM_FINAL  = 4'd9
    } t_op;

    // Branch conditions reported back to the controller.
    typedef struct packed {
        logic walk_go;
        logic free_scan;
        logic free_done;
        logic rm_go;
        logic rm_hit;
        logic round_done;
        logic seek_go;
        logic seek_hit;
        logic prev_null;
        logic scan_hit;
        logic scan_last;
    } t_status;

    // Home slot: magnitude of the key modulo the table size.
    function automatic logic [IDX_W-1:0] home_of(input logic [31:0] k);
        logic [31:0] mag;
        mag = k[31] ? (~k + 32'd1) : k;
        return IDX_W'(mag % CAPACITY);
    endfunction

endpackage

>>> hw/rtl/chm_ctrl.sv
// Command sequencer for the coalesced hash map core.
module chm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_command,
    input  chm_pkg::t_status i_status,
    output chm_pkg::t_op    o_op,
    output logic            busy,
    output logic            o_done
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_WALK      = 10'b00_0000_0010,
        S_FREE      = 10'b00_0000_0100,
        S_RM_WALK   = 10'b00_0000_1000,
        S_RM_ROUND  = 10'b00_0001_0000,
        S_RM_SEEK   = 10'b00_0010_0000,
        S_RM_UNLINK = 10'b00_0100_0000,
        S_RM_SCAN   = 10'b00_1000_0000,
        S_RM_FINAL  = 10'b01_0000_0000,
        S_REPORT    = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_op    = chm_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_op = chm_pkg::OP_LOAD;
                    n_state = (i_command == chm_pkg::CMD_REMOVE) ? S_RM_WALK : S_WALK;
                end
            end
            S_WALK: begin
                o_op = chm_pkg::OP_WALK;
                if (!i_status.walk_go) begin
                    n_state = i_status.free_scan ? S_FREE : S_REPORT;
                end
            end
            S_FREE: begin
                o_op = chm_pkg::OP_FREE;
                if (i_status.free_done) begin
                    n_state = S_REPORT;
                end
            end
            S_RM_WALK: begin
                o_op = chm_pkg::OP_RM_WALK;
                if (!i_status.rm_go) begin
                    n_state = i_status.rm_hit ? S_RM_ROUND : S_REPORT;
                end
            end
            S_RM_ROUND: begin
                o_op = chm_pkg::OP_RM_ROUND;
                n_state = i_status.round_done ? S_RM_UNLINK : S_RM_SEEK;
            end
            S_RM_SEEK: begin
                o_op = chm_pkg::OP_RM_SEEK;
                if (!i_status.seek_go) begin
                    n_state = i_status.seek_hit ? S_RM_ROUND : S_RM_UNLINK;
                end
            end
            S_RM_UNLINK: begin
                o_op = chm_pkg::OP_RM_UNLINK;
                n_state = i_status.prev_null ? S_RM_SCAN : S_RM_FINAL;
            end
            S_RM_SCAN: begin
                o_op = chm_pkg::OP_RM_SCAN;
                if (i_status.scan_hit || i_status.scan_last) begin
                    n_state = S_RM_FINAL;
                end
            end
            S_RM_FINAL: begin
                o_op = chm_pkg::OP_RM_FINAL;
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_REPORT);

endmodule

>>> hw/rtl/chm_datapath.sv
// Slot table, chain pointers and result registers of the coalesced hash map core.
module chm_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  chm_pkg::t_op                i_op,
    input  logic [1:0]                  i_command,
    input  logic signed [31:0]          i_key,
    input  logic signed [31:0]          i_value,
    input  logic signed [31:0]          i_old_value,
    output chm_pkg::t_status            o_status,
    output logic                        o_found,
    output logic signed [31:0]          o_result_value,
    output logic                        o_table_full,
    output logic [chm_pkg::CNT_W-1:0]   o_entry_count,
    output logic                        o_is_empty
);

    localparam int IW = chm_pkg::IDX_W;
    localparam int SW = chm_pkg::SLOT_W;

    logic [31:0]    r_keys [chm_pkg::CAPACITY];
    logic [31:0]    r_vals [chm_pkg::CAPACITY];
    logic           r_used [chm_pkg::CAPACITY];
    logic [SW-1:0]  r_link [chm_pkg::CAPACITY];

    logic [1:0]     r_cmd;
    logic [31:0]    r_key, r_val, r_old, r_res;
    logic [SW-1:0]  r_cur, r_prev, r_pos, r_before, r_scan, r_free;
    logic [SW-1:0]  r_steps, r_walk, r_round;
    logic [chm_pkg::CNT_W-1:0] r_count;
    logic           r_found, r_full;

    // one table read address per cycle
    logic [IW-1:0]  rd_a;
    logic [31:0]    rd_key, rd_val;
    logic [SW-1:0]  rd_link, nxt;
    logic           rd_used, rd_ok, cur_ok, pos_ok;
    logic           holds, home_ins, chain_ins, free_full, match;

    logic           key_we, val_we;
    logic [IW-1:0]  wr_a;
    logic [31:0]    wr_key, wr_val;

    always_comb begin
        case (i_op)
            chm_pkg::OP_RM_SEEK: rd_a = r_pos[IW-1:0];
            chm_pkg::OP_RM_SCAN,
            chm_pkg::OP_FREE:    rd_a = r_scan[IW-1:0];
            default:             rd_a = r_cur[IW-1:0];
        endcase
    end

    assign rd_key  = r_keys[rd_a];
    assign rd_val  = r_vals[rd_a];
    assign rd_link = r_link[rd_a];
    assign rd_used = r_used[rd_a];

    assign cur_ok    = (r_cur < chm_pkg::NULL_LINK);
    assign pos_ok    = (r_pos < chm_pkg::NULL_LINK);
    assign rd_ok     = (i_op == chm_pkg::OP_RM_SEEK) ? pos_ok : cur_ok;
    assign nxt       = (rd_ok && rd_link < chm_pkg::NULL_LINK) ? rd_link : chm_pkg::NULL_LINK;
    assign holds     = cur_ok && rd_used && (rd_key == r_key);
    assign free_full = (r_free >= chm_pkg::NULL_LINK);
    assign home_ins  = (r_cmd == chm_pkg::CMD_ADD) && (r_steps == '0) && !rd_used;
    assign chain_ins = (r_cmd == chm_pkg::CMD_ADD) && !home_ins && !holds && !free_full
                       && (nxt == chm_pkg::NULL_LINK);
    assign match     = pos_ok && ({1'b0, chm_pkg::home_of(rd_key)} == r_cur);

    always_comb begin
        o_status.walk_go    = !home_ins && (nxt != chm_pkg::NULL_LINK) && !holds
                              && (r_steps < chm_pkg::NULL_LINK);
        o_status.free_scan  = (home_ins && ({1'b0, rd_a} == r_free)) || chain_ins;
        o_status.free_done  = (r_scan >= chm_pkg::NULL_LINK) || !rd_used;
        o_status.rm_go      = cur_ok && !holds && (r_steps < chm_pkg::NULL_LINK);
        o_status.rm_hit     = holds;
        o_status.round_done = (r_round == chm_pkg::NULL_LINK);
        o_status.seek_go    = pos_ok && !match && (r_walk < chm_pkg::NULL_LINK);
        o_status.seek_hit   = match;
        o_status.prev_null  = (r_prev == chm_pkg::NULL_LINK);
        o_status.scan_hit   = (rd_link == r_cur);
        o_status.scan_last  = (r_scan == chm_pkg::LAST_SLOT);
    end

    // key/value write port
    always_comb begin
        key_we = 1'b0;
        val_we = 1'b0;
        wr_a   = rd_a;
        wr_key = r_key;
        wr_val = r_val;
        case (i_op)
            chm_pkg::OP_WALK: begin
                if (home_ins) begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                end else if (holds && r_cmd == chm_pkg::CMD_ADD) begin
                    val_we = 1'b1;
                end else if (chain_ins) begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                    wr_a   = r_free[IW-1:0];
                end else if (holds && r_cmd == chm_pkg::CMD_REPLACE && rd_val == r_old) begin
                    val_we = 1'b1;
                end
            end
            chm_pkg::OP_RM_SEEK: begin
                if (match) begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                    wr_a   = r_cur[IW-1:0];
                    wr_key = rd_key;
                    wr_val = rd_val;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            r_keys[wr_a] <= wr_key;
        end
        if (val_we) begin
            r_vals[wr_a] <= wr_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < chm_pkg::CAPACITY; i++) begin
                r_used[i] <= 1'b0;
                r_link[i] <= chm_pkg::NULL_LINK;
            end
            r_free  <= '0;
            r_count <= '0;
            r_cmd   <= chm_pkg::CMD_SEARCH;
        end else begin
            case (i_op)
                chm_pkg::OP_LOAD: begin
                    r_cmd   <= i_command;
                    r_key   <= i_key;
                    r_val   <= i_value;
                    r_old   <= i_old_value;
                    r_cur   <= {1'b0, chm_pkg::home_of(i_key)};
                    r_prev  <= chm_pkg::NULL_LINK;
                    r_steps <= '0;
                    r_found <= 1'b0;
                    r_full  <= 1'b0;
                    r_res   <= '0;
                end
                chm_pkg::OP_WALK: begin
                    if (o_status.walk_go) begin
                        r_cur   <= nxt;
                        r_steps <= r_steps + 1'b1;
                    end else begin
                        r_scan <= r_free + 1'b1;
                        if (home_ins) begin
                            r_used[rd_a] <= 1'b1;
                            r_link[rd_a] <= chm_pkg::NULL_LINK;
                            r_count      <= r_count + 1'b1;
                        end else if (holds) begin
                            r_found <= 1'b1;
                            r_res   <= rd_val;
                        end else if (r_cmd == chm_pkg::CMD_ADD && free_full) begin
                            r_full <= 1'b1;
                        end else if (chain_ins) begin
                            r_used[r_free[IW-1:0]] <= 1'b1;
                            r_link[r_free[IW-1:0]] <= chm_pkg::NULL_LINK;
                            r_link[rd_a]           <= r_free;
                            r_count                <= r_count + 1'b1;
                        end
                    end
                end
                chm_pkg::OP_FREE: begin
                    if (o_status.free_done) begin
                        r_free <= (r_scan >= chm_pkg::NULL_LINK) ? chm_pkg::NULL_LINK : r_scan;
                    end else begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                chm_pkg::OP_RM_WALK: begin
                    if (o_status.rm_go) begin
                        r_prev  <= r_cur;
                        r_cur   <= nxt;
                        r_steps <= r_steps + 1'b1;
                    end else if (holds) begin
                        r_found <= 1'b1;
                        r_res   <= rd_val;
                        r_round <= '0;
                    end
                end
                chm_pkg::OP_RM_ROUND: begin
                    if (!o_status.round_done) begin
                        r_pos    <= nxt;
                        r_before <= r_cur;
                        r_walk   <= '0;
                    end
                end
                chm_pkg::OP_RM_SEEK: begin
                    if (o_status.seek_go) begin
                        r_before <= r_pos;
                        r_pos    <= nxt;
                        r_walk   <= r_walk + 1'b1;
                    end else if (match) begin
                        r_prev  <= r_before;
                        r_cur   <= r_pos;
                        r_round <= r_round + 1'b1;
                    end
                end
                chm_pkg::OP_RM_UNLINK: begin
                    if (o_status.prev_null) begin
                        r_scan <= '0;
                    end
                end
                chm_pkg::OP_RM_SCAN: begin
                    if (o_status.scan_hit) begin
                        r_prev <= r_scan;
                    end else if (!o_status.scan_last) begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
                chm_pkg::OP_RM_FINAL: begin
                    // bypass the vacated slot, then release it
                    if (!o_status.prev_null) begin
                        r_link[r_prev[IW-1:0]] <= rd_link;
                    end
                    r_used[rd_a] <= 1'b0;
                    r_link[rd_a] <= chm_pkg::NULL_LINK;
                    if (r_count != '0) begin
                        r_count <= r_count - 1'b1;
                    end
                    if (r_free > r_cur) begin
                        r_free <= r_cur;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_found        = r_found;
    assign o_result_value = signed'(r_res);
    assign o_table_full   = r_full;
    assign o_entry_count  = r_count;
    assign o_is_empty     = (r_count == '0);

endmodule

>>> hw/rtl/coalesced_hash_map_core.sv
// Top level of the coalesced hash map core: sequencer plus slot datapath.
//
// Usage:
//   A command transfer happens on a rising edge with start high and busy low;
//   i_command, i_key, i_value and i_old_value are sampled at that edge.
//   busy stays high until the result is presented. The result is on
//   o_found, o_result_value, o_table_full, o_entry_count and o_is_empty,
//   flagged by o_done for exactly one cycle; the receiver cannot stall it, so
//   it must capture the result in that cycle.
// Sequencing, one slot visited per cycle:
//   search/replace/add: load, then walk the chain (+ free-slot scan after an
//   insert that took the lowest free slot).
//   remove: chain walk, then per refill round one slot per chain step, an
//   optional predecessor scan, and a final release step.
// One command at a time; busy drops the cycle after o_done.
// Reset (synchronous, i_rst_n low): table empty, all links null, count and
//   lowest free slot zero, sequencer idle. No clearing pass is needed.
module coalesced_hash_map_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_command,
    input  logic signed [31:0]          i_key,
    input  logic signed [31:0]          i_value,
    input  logic signed [31:0]          i_old_value,
    output logic                        o_done,
    output logic                        o_found,
    output logic signed [31:0]          o_result_value,
    output logic                        o_table_full,
    output logic [chm_pkg::CNT_W-1:0]   o_entry_count,
    output logic                        o_is_empty
);

    chm_pkg::t_op     op;
    chm_pkg::t_status status;

    chm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_command (i_command),
        .i_status  (status),
        .o_op      (op),
        .busy      (busy),
        .o_done    (o_done)
    );

    chm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_old_value    (i_old_value),
        .o_status       (status),
        .o_found        (o_found),
        .o_result_value (o_result_value),
        .o_table_full   (o_table_full),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty)
    );

    // accepted command always produces busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    // result strobe lasts one cycle and frees the core
    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

    // a refused add never reports a hit
    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_table_full) |-> !o_found)
        else $error("table_full together with found");

    // stored count never exceeds the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_entry_count <= chm_pkg::CNT_W'(chm_pkg::CAPACITY)))
        else $error("entry count above capacity");

endmodule
